### rtl/i2cms_pkg.sv
// ============================================================================
// i2cms_pkg
// Shared types and codes of the I2C master transaction sequencer.
// ============================================================================
`default_nettype none

package i2cms_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_TX_BYTE = 2'd1;
    localparam logic [1:0] OP_EVENT   = 2'd2;

    localparam logic [1:0] EV_SENT     = 2'd0;
    localparam logic [1:0] EV_RECEIVED = 2'd1;
    localparam logic [1:0] EV_STOPPED  = 2'd2;
    localparam logic [1:0] EV_ERROR    = 2'd3;

    localparam logic [3:0] ACT_START_TX    = 4'd0;
    localparam logic [3:0] ACT_SEND_BYTE   = 4'd1;
    localparam logic [3:0] ACT_START_RX_AK = 4'd2;
    localparam logic [3:0] ACT_START_RX_NK = 4'd3;
    localparam logic [3:0] ACT_RESUME_AK   = 4'd4;
    localparam logic [3:0] ACT_RESUME_NK   = 4'd5;
    localparam logic [3:0] ACT_STOP        = 4'd6;
    localparam logic [3:0] ACT_REQUEST     = 4'd7;
    localparam logic [3:0] ACT_RX_DATA     = 4'd8;
    localparam logic [3:0] ACT_DONE        = 4'd9;

    typedef struct packed {
        logic [1:0] op;
        logic       kind;
        logic [6:0] dev_addr;
        logic [7:0] cmd_count;
        logic [7:0] data_count;
        logic [7:0] tx_byte;
        logic [1:0] event_code;
        logic [7:0] rx_byte;
        logic [2:0] error_source;
    } t_item;

    typedef struct packed {
        logic [3:0] action;
        logic [6:0] target_addr;
        logic [7:0] out_byte;
        logic [7:0] in_byte;
        logic [7:0] byte_index;
        logic       byte_group;
        logic       status;
        logic [2:0] error_bits;
        logic       last;
    } t_result;

    typedef struct packed {
        logic       take;
        logic [1:0] count;
    } t_push;

    function automatic t_result blank_result(input logic [3:0] action);
        t_result r;
        r        = '0;
        r.action = action;
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/i2c_master_transaction_sequencer.sv
// ============================================================================
// i2c_master_transaction_sequencer
// Sequences write and command-then-read transactions for a byte-level I2C
// master engine: asks for transmit bytes, hands over received bytes, reports.
// ============================================================================
//
//  Channel  Direction  Payload (tdata / tuser / tlast)
//  s        in         command or engine event / op / -
//  m        out        engine command or client reply / action / last
//
// An accepted item is held in the input register, where it is evaluated;
// its one or two results are written into the registered result queue when
// the queue has room, and the first result is then offered from the queue.
// The block takes an item every cycle while the queue has two free entries;
// an item with two results fills two. Results leave one a cycle on m tready.
// Synchronous reset returns the sequencer to idle and empties the queue.
// A stall on the m side only fills the queue; it then holds s tready low.
`default_nettype none

module i2c_master_transaction_sequencer #(
    parameter int P_FIFO_DEPTH = i2cms_pkg::FIFO_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // kind[0], dev_addr[7:1], cmd_count[15:8], data_count[23:16],
    // tx_byte[31:24], event_code[33:32], rx_byte[41:34], error_source[44:42]
    input  wire  [47:0] i_s_tdata,
    // op[1:0]
    input  wire  [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // target_addr[6:0], out_byte[14:7], in_byte[22:15], byte_index[30:23],
    // byte_group[31], status[32], error_bits[35:33]
    output logic [39:0] o_m_tdata,
    // action[3:0]
    output logic [3:0]  o_m_tuser,
    output logic        o_m_tlast
);

    logic                 r_in_valid;
    i2cms_pkg::t_item     r_item;
    logic                 w_room;
    logic                 w_accept;
    i2cms_pkg::t_push     w_push;
    i2cms_pkg::t_result   w_res0;
    i2cms_pkg::t_result   w_res1;
    i2cms_pkg::t_result   w_out;

    assign o_s_tready = !r_in_valid || w_push.take;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.op           <= i_s_tuser;
            r_item.kind         <= i_s_tdata[0];
            r_item.dev_addr     <= i_s_tdata[7:1];
            r_item.cmd_count    <= i_s_tdata[15:8];
            r_item.data_count   <= i_s_tdata[23:16];
            r_item.tx_byte      <= i_s_tdata[31:24];
            r_item.event_code   <= i_s_tdata[33:32];
            r_item.rx_byte      <= i_s_tdata[41:34];
            r_item.error_source <= i_s_tdata[44:42];
        end
    end

    i2cms_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_room  (w_room),
        .i_item  (r_item),
        .o_push  (w_push),
        .o_res0  (w_res0),
        .o_res1  (w_res1)
    );

    i2cms_result_fifo #(
        .P_DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res0  (w_res0),
        .i_res1  (w_res1),
        .o_room  (w_room),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (w_out)
    );

    assign o_m_tdata = {4'd0, w_out.error_bits, w_out.status, w_out.byte_group,
                        w_out.byte_index, w_out.in_byte, w_out.out_byte,
                        w_out.target_addr};
    assign o_m_tuser = w_out.action;
    assign o_m_tlast = w_out.last;

endmodule

`default_nettype wire

### rtl/i2cms_core.sv
// ============================================================================
// i2cms_core
// Transaction state and the logic that turns one item into up to two results.
// ============================================================================
`default_nettype none

module i2cms_core (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    input  wire                     i_room,
    input  wire i2cms_pkg::t_item   i_item,
    output i2cms_pkg::t_push        o_push,
    output i2cms_pkg::t_result      o_res0,
    output i2cms_pkg::t_result      o_res1
);

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_TX_CMD    = 3'd1;
    localparam logic [2:0] PH_TX_DATA   = 3'd2;
    localparam logic [2:0] PH_SENT_CMD  = 3'd3;
    localparam logic [2:0] PH_SENT_DATA = 3'd4;
    localparam logic [2:0] PH_RX        = 3'd5;
    localparam logic [2:0] PH_STOP      = 3'd6;

    logic [2:0] r_phase,    n_phase;
    logic       r_is_read,  n_is_read;
    logic [6:0] r_addr,     n_addr;
    logic [7:0] r_cmd_tot,  n_cmd_tot;
    logic [7:0] r_data_tot, n_data_tot;
    logic [7:0] r_position, n_position;
    logic [2:0] r_err,      n_err;
    logic       r_failed,   n_failed;

    logic                 w_take;
    logic                 w_start;
    logic                 w_sel_rd;
    logic [7:0]           w_sel_dc;
    logic [6:0]           w_sel_addr;
    i2cms_pkg::t_result   w_ac_res;
    logic [2:0]           w_ac_phase;
    logic [8:0]           w_next;
    logic [9:0]           w_next2;
    i2cms_pkg::t_result   w_r0;
    i2cms_pkg::t_result   w_r1;
    logic [1:0]           w_cnt;
    logic [2:0]           w_err_or;

    assign w_take  = i_valid && i_room;
    assign w_start = (i_item.op == i2cms_pkg::OP_START) && (r_phase == PH_IDLE);
    assign w_next  = {1'b0, r_position} + 9'd1;
    assign w_next2 = {1'b0, w_next} + 10'd1;
    assign w_err_or = r_err | i_item.error_source;

    assign w_sel_rd   = w_start ? i_item.kind       : r_is_read;
    assign w_sel_dc   = w_start ? i_item.data_count : r_data_tot;
    assign w_sel_addr = w_start ? i_item.dev_addr   : r_addr;

    // Step taken once all command bytes are out.
    always_comb begin
        if (w_sel_dc == 8'd0) begin
            w_ac_res   = i2cms_pkg::blank_result(i2cms_pkg::ACT_STOP);
            w_ac_phase = PH_STOP;
        end else if (!w_sel_rd) begin
            w_ac_res            = i2cms_pkg::blank_result(i2cms_pkg::ACT_REQUEST);
            w_ac_res.byte_group = 1'b1;
            w_ac_phase          = PH_TX_DATA;
        end else begin
            w_ac_res = i2cms_pkg::blank_result((w_sel_dc > 8'd1) ?
                           i2cms_pkg::ACT_START_RX_AK : i2cms_pkg::ACT_START_RX_NK);
            w_ac_res.target_addr = w_sel_addr;
            w_ac_phase           = PH_RX;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_is_read  = r_is_read;
        n_addr     = r_addr;
        n_cmd_tot  = r_cmd_tot;
        n_data_tot = r_data_tot;
        n_position = r_position;
        n_err      = r_err;
        n_failed   = r_failed;
        w_r0       = '0;
        w_r1       = '0;
        w_cnt      = 2'd0;
        unique case (i_item.op)
            i2cms_pkg::OP_START: begin
                if (r_phase == PH_IDLE) begin
                    n_is_read  = i_item.kind;
                    n_addr     = i_item.dev_addr;
                    n_cmd_tot  = i_item.cmd_count;
                    n_data_tot = i_item.data_count;
                    n_position = 8'd0;
                    n_err      = 3'd0;
                    n_failed   = 1'b0;
                    if (i_item.cmd_count != 8'd0) begin
                        w_r1    = i2cms_pkg::blank_result(i2cms_pkg::ACT_REQUEST);
                        n_phase = PH_TX_CMD;
                    end else begin
                        w_r1    = w_ac_res;
                        n_phase = w_ac_phase;
                    end
                    if (!i_item.kind || i_item.cmd_count != 8'd0) begin
                        w_r0 = i2cms_pkg::blank_result(i2cms_pkg::ACT_START_TX);
                        w_r0.target_addr = i_item.dev_addr;
                        w_cnt = 2'd2;
                    end else begin
                        w_r0  = w_r1;
                        w_r1  = '0;
                        w_cnt = 2'd1;
                    end
                end
            end
            i2cms_pkg::OP_TX_BYTE: begin
                if (r_phase == PH_TX_CMD || r_phase == PH_TX_DATA) begin
                    n_phase = (r_phase == PH_TX_CMD) ? PH_SENT_CMD : PH_SENT_DATA;
                    w_r0 = i2cms_pkg::blank_result(i2cms_pkg::ACT_SEND_BYTE);
                    w_r0.out_byte = i_item.tx_byte;
                    w_cnt = 2'd1;
                end
            end
            i2cms_pkg::OP_EVENT: begin
                if (r_phase == PH_SENT_CMD || r_phase == PH_SENT_DATA) begin
                    if (i_item.event_code == i2cms_pkg::EV_ERROR) begin
                        n_failed = 1'b1;
                        n_err    = i_item.error_source;
                        n_phase  = PH_STOP;
                        w_r0     = i2cms_pkg::blank_result(i2cms_pkg::ACT_STOP);
                        w_cnt    = 2'd1;
                    end else if (i_item.event_code == i2cms_pkg::EV_SENT) begin
                        w_cnt = 2'd1;
                        if (r_phase == PH_SENT_CMD) begin
                            if (w_next < {1'b0, r_cmd_tot}) begin
                                n_position = w_next[7:0];
                                n_phase    = PH_TX_CMD;
                                w_r0 = i2cms_pkg::blank_result(i2cms_pkg::ACT_REQUEST);
                                w_r0.byte_index = w_next[7:0];
                            end else begin
                                n_position = 8'd0;
                                n_phase    = w_ac_phase;
                                w_r0       = w_ac_res;
                            end
                        end else begin
                            if (w_next < {1'b0, r_data_tot}) begin
                                n_position = w_next[7:0];
                                n_phase    = PH_TX_DATA;
                                w_r0 = i2cms_pkg::blank_result(i2cms_pkg::ACT_REQUEST);
                                w_r0.byte_index = w_next[7:0];
                                w_r0.byte_group = 1'b1;
                            end else begin
                                n_phase = PH_STOP;
                                w_r0 = i2cms_pkg::blank_result(i2cms_pkg::ACT_STOP);
                            end
                        end
                    end
                end else if (r_phase == PH_RX) begin
                    if (i_item.event_code == i2cms_pkg::EV_ERROR) begin
                        n_failed = 1'b1;
                        n_err    = i_item.error_source;
                        n_phase  = PH_STOP;
                        w_r0     = i2cms_pkg::blank_result(i2cms_pkg::ACT_STOP);
                        w_cnt    = 2'd1;
                    end else if (i_item.event_code == i2cms_pkg::EV_RECEIVED) begin
                        w_r0 = i2cms_pkg::blank_result(i2cms_pkg::ACT_RX_DATA);
                        w_r0.in_byte    = i_item.rx_byte;
                        w_r0.byte_index = r_position;
                        if (w_next < {1'b0, r_data_tot}) begin
                            n_position = w_next[7:0];
                            w_r1 = i2cms_pkg::blank_result(
                                       (w_next2 < {2'b00, r_data_tot}) ?
                                       i2cms_pkg::ACT_RESUME_AK :
                                       i2cms_pkg::ACT_RESUME_NK);
                            w_cnt = 2'd2;
                        end else begin
                            n_phase = PH_STOP;
                            w_cnt   = 2'd1;
                        end
                    end
                end else if (r_phase == PH_STOP) begin
                    if (i_item.event_code == i2cms_pkg::EV_STOPPED ||
                        i_item.event_code == i2cms_pkg::EV_ERROR) begin
                        if (i_item.event_code == i2cms_pkg::EV_ERROR && r_failed) begin
                            n_err = w_err_or;
                        end
                        w_r0 = i2cms_pkg::blank_result(i2cms_pkg::ACT_DONE);
                        w_r0.status     = r_failed;
                        w_r0.error_bits = r_failed ? n_err : 3'd0;
                        n_phase = PH_IDLE;
                        w_cnt   = 2'd1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (w_cnt == 2'd2) begin
            w_r1.last = 1'b1;
        end else begin
            w_r0.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_is_read  <= 1'b0;
            r_addr     <= 7'd0;
            r_cmd_tot  <= 8'd0;
            r_data_tot <= 8'd0;
            r_position <= 8'd0;
            r_err      <= 3'd0;
            r_failed   <= 1'b0;
        end else if (w_take) begin
            r_phase    <= n_phase;
            r_is_read  <= n_is_read;
            r_addr     <= n_addr;
            r_cmd_tot  <= n_cmd_tot;
            r_data_tot <= n_data_tot;
            r_position <= n_position;
            r_err      <= n_err;
            r_failed   <= n_failed;
        end
    end

    assign o_push.take  = w_take;
    assign o_push.count = w_take ? w_cnt : 2'd0;
    assign o_res0       = w_r0;
    assign o_res1       = w_r1;

endmodule

`default_nettype wire

### rtl/i2cms_result_fifo.sv
// ============================================================================
// i2cms_result_fifo
// Small register queue that takes up to two results a cycle and gives one on ready.
// ============================================================================
`default_nettype none

module i2cms_result_fifo #(
    parameter int P_DEPTH = i2cms_pkg::FIFO_DEPTH
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire i2cms_pkg::t_push   i_push,
    input  wire i2cms_pkg::t_result i_res0,
    input  wire i2cms_pkg::t_result i_res1,
    output logic                    o_room,
    output logic                    o_valid,
    input  wire                     i_ready,
    output i2cms_pkg::t_result      o_res
);

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(P_DEPTH - 1);
    localparam logic [CW-1:0] ROOM_MAX = CW'(P_DEPTH - 2);

    i2cms_pkg::t_result r_mem [P_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic [PW-1:0] w_wr_ptr1;
    logic          w_pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PW'(1);
    endfunction

    assign w_pop     = (r_count != '0) && i_ready;
    assign w_wr_ptr1 = ptr_inc(r_wr_ptr);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = w_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        unique case (i_push.count)
            2'd1:    n_wr_ptr = w_wr_ptr1;
            2'd2:    n_wr_ptr = ptr_inc(w_wr_ptr1);
            default: n_wr_ptr = r_wr_ptr;
        endcase
        n_count = r_count + CW'(i_push.count) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr_ptr1] <= i_res1;
        end
    end

    assign o_room  = (r_count <= ROOM_MAX);
    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd_ptr];

endmodule

`default_nettype wire
